// ===== sv/ssbpm_pkg.sv =====
// Shared types, constants and helpers for the SSB polar modulator.
`default_nettype none
package ssbpm_pkg;

	localparam int unsigned DECIMATION_DEF = 2;
	localparam int unsigned FIR_LEN = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned DIV_W = 22;
	localparam int unsigned QUO_W = 7;
	localparam int unsigned STEP_CNT_W = 3;
	localparam logic [STEP_CNT_W-1:0] DIV1_STEPS = 3'd6;
	localparam logic [STEP_CNT_W-1:0] DIV2_STEPS = 3'd7;
	localparam logic [QUO_W-1:0] ATAN_BASE = 7'd120;
	localparam logic [7:0] ATAN_QUARTER = 8'd176;
	localparam logic signed [10:0] CIRCLE_HALF = 11'sd352;
	localparam logic signed [11:0] CIRCLE_FULL = 12'sd704;

	localparam logic [7:0] GAIN_RST = 8'd8;
	localparam logic [15:0] FREQ_SCALE_RST = 16'd1454;
	localparam logic [15:0] PWM_HALF_RST = 16'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE,
		REG_LSB_MODE,
		REG_GAIN,
		REG_FREQ_SCALE,
		REG_PWM_HALF
	} cfg_idx_t;

	typedef struct packed {
		logic        enable;
		logic        lsb_mode;
		logic [7:0]  gain;
		logic [15:0] freq_scale;
		logic [15:0] pwm_half_count;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILT,
		S_SHIFT,
		S_HILB,
		S_POLAR,
		S_DIV1_GO,
		S_DIV1,
		S_MUL2,
		S_DIV2_GO,
		S_DIV2,
		S_PHASE,
		S_SCALE,
		S_PWM,
		S_OUT
	} state_t;

	typedef struct packed {
		logic acc;
		logic filt;
		logic shift;
		logic hilb;
		logic polar;
		logic div_start;
		logic div_sel;
		logic mul2;
		logic phase;
		logic scale;
		logic pwm;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic period_done;
		logic div_done;
	} stat_t;

	// signed divide by 2**sh, truncating toward zero
	function automatic logic signed [23:0] sdiv_pow2(input logic signed [23:0] v,
		input int unsigned sh);
		logic signed [23:0] bias;
		bias = v[23] ? 24'((1 << sh) - 1) : 24'sd0;
		return (v + bias) >>> sh;
	endfunction

endpackage
`default_nettype wire

// ===== sv/ssbpm_div.sv =====
// Restoring divider producing a short quotient, one bit per cycle.
`default_nettype none
module ssbpm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ssbpm_pkg::DIV_W-1:0]  dividend,
	input  wire logic [ssbpm_pkg::DIV_W-1:0]  divisor_top,
	input  wire logic [ssbpm_pkg::STEP_CNT_W-1:0] steps,
	output logic                              done,
	output logic [ssbpm_pkg::QUO_W-1:0]       quotient
);
	import ssbpm_pkg::*;

	logic [DIV_W-1:0]      rem_q;
	logic [DIV_W-1:0]      ds_q;
	logic [QUO_W-1:0]      quo_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  fits;

	assign fits = rem_q >= ds_q;
	assign done = busy_q && (cnt_q == STEP_CNT_W'(1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			ds_q <= divisor_top;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - ds_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], fits};
			ds_q <= ds_q >> 1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/ssbpm_dp.sv =====
// Datapath: accumulator, filters, delay line, Hilbert FIR, polar conversion, scaling.
`default_nettype none
module ssbpm_dp #(
	parameter int unsigned DECIMATION = ssbpm_pkg::DECIMATION_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ssbpm_pkg::cmd_t    cmd,
	input  wire ssbpm_pkg::cfg_t    cfg,
	input  wire logic signed [15:0] sample,
	output ssbpm_pkg::stat_t        stat,
	output logic [7:0]              envelope,
	output logic [15:0]             pwm_level,
	output logic signed [15:0]      freq_offset
);
	import ssbpm_pkg::*;

	localparam int unsigned CNT_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

	logic signed [15:0] sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [15:0] lp_q, dc_q, ac_q;
	logic signed [15:0] dl_q [FIR_LEN];
	logic signed [15:0] x_q, y_q;
	logic [15:0]        num_q, den_q, mag_q;
	logic               swap_q, xneg_q, yneg_q, zero_q;
	logic [DIV_W-1:0]   dvd2_q;
	logic signed [10:0] last_phase_q;
	logic [9:0]         step_q;
	logic [23:0]        env_prod_q;
	logic [7:0]         env_q;
	logic [25:0]        freq_prod_q;
	logic [23:0]        pwm_prod_q;
	logic [7:0]         envelope_q;
	logic [15:0]        pwm_level_q;
	logic signed [15:0] freq_offset_q;
	logic               period_done_w;
	logic               div_done_w;

	assign stat = '{period_done: period_done_w, div_done: div_done_w};

	// accumulate
	logic signed [15:0] sum_next;
	assign sum_next = sum_q + sample;
	assign period_done_w = (cnt_q == CNT_W'(DECIMATION - 1));

	// low-pass and DC removal
	logic signed [15:0] ac_w, lp_new, dc_new, tap;
	logic signed [18:0] lp_num, dc_num;
	assign ac_w = {sum_q[14:0], 1'b0} + lp_q;
	assign lp_num = 19'(sum_q) - (19'(lp_q) <<< 1) - 19'(lp_q);
	assign dc_num = 19'(ac_w) + (19'(dc_q) <<< 1) + 19'(dc_q);
	assign lp_new = 16'(sdiv_pow2(24'(lp_num), 2));
	assign dc_new = 16'(sdiv_pow2(24'(dc_num), 2));
	assign tap = 16'(sdiv_pow2(24'(17'(ac_q) - 17'(dc_q)), 1));

	// Hilbert FIR, antisymmetric taps
	logic signed [16:0] e0, e2, e4, e6;
	logic signed [23:0] hacc, hq;
	assign e0 = 17'(dl_q[0]) - 17'(dl_q[14]);
	assign e2 = 17'(dl_q[2]) - 17'(dl_q[12]);
	assign e4 = 17'(dl_q[4]) - 17'(dl_q[10]);
	assign e6 = 17'(dl_q[6]) - 17'(dl_q[8]);
	assign hacc = (24'(e0) <<< 1) + (24'(e2) <<< 3)
		+ (24'(e4) <<< 4) + (24'(e4) <<< 2) + 24'(e4)
		+ (24'(e6) <<< 4) - 24'(e6);
	assign hq = sdiv_pow2(hacc, 7) + sdiv_pow2(24'(e6), 1);

	// octagon magnitude and argument ordering
	logic [15:0] ux, uy, num_w, den_w;
	logic        swap_w;
	assign ux = x_q[15] ? 16'(-17'(x_q)) : 16'(x_q);
	assign uy = y_q[15] ? 16'(-17'(y_q)) : 16'(y_q);
	assign swap_w = uy > ux;
	assign num_w = swap_w ? ux : uy;
	assign den_w = swap_w ? uy : ux;

	// divider, shared by both arctangent divisions
	logic [DIV_W-1:0]      div_dvd, div_top;
	logic [STEP_CNT_W-1:0] div_steps;
	logic [QUO_W-1:0]      quo;
	logic [22:0]           m2;
	logic [QUO_W-1:0]      atan_t;
	assign div_dvd = cmd.div_sel ? dvd2_q : {1'b0, num_q, 5'b0};
	assign div_top = cmd.div_sel ? {den_q, 6'b0} : {1'b0, den_q, 5'b0};
	assign div_steps = cmd.div_sel ? DIV2_STEPS : DIV1_STEPS;
	// the first quotient is complete and held in the divider during the multiply
	assign atan_t = ATAN_BASE - quo;
	assign m2 = 23'(atan_t) * 23'(num_q);

	ssbpm_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cmd.div_start),
		.dividend    (div_dvd),
		.divisor_top (div_top),
		.steps       (div_steps),
		.done        (div_done_w),
		.quotient    (quo)
	);

	// phase and phase step
	logic [7:0]         ph;
	logic signed [10:0] p1, phase_w;
	logic signed [11:0] diff, step_w;
	assign ph = swap_q ? (ATAN_QUARTER - {1'b0, quo}) : (zero_q ? 8'd0 : {1'b0, quo});
	assign p1 = xneg_q ? (CIRCLE_HALF - $signed({3'b0, ph})) : $signed({3'b0, ph});
	assign phase_w = yneg_q ? -p1 : p1;
	assign diff = 12'(phase_w) - 12'(last_phase_q);
	assign step_w = diff[11] ? (diff + CIRCLE_FULL) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			lp_q <= '0;
			dc_q <= '0;
			last_phase_q <= '0;
			for (int i = 0; i < FIR_LEN; i++) begin
				dl_q[i] <= '0;
			end
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_next;
				cnt_q <= period_done_w ? '0 : cnt_q + CNT_W'(1);
			end
			if (cmd.filt) begin
				sum_q <= '0;
				lp_q <= lp_new;
				dc_q <= dc_new;
			end
			if (cmd.shift) begin
				for (int i = 0; i < FIR_LEN - 1; i++) begin
					dl_q[i] <= dl_q[i+1];
				end
				dl_q[FIR_LEN-1] <= tap;
			end
			if (cmd.phase) begin
				last_phase_q <= phase_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.filt) begin
			ac_q <= ac_w;
		end
		if (cmd.hilb) begin
			x_q <= dl_q[FIR_LEN/2 - 1];
			y_q <= hq[15:0];
		end
		if (cmd.polar) begin
			num_q <= num_w;
			den_q <= den_w;
			mag_q <= den_w + (num_w >> 2);
			swap_q <= swap_w;
			xneg_q <= x_q[15];
			yneg_q <= y_q[15];
			zero_q <= (ux == 16'd0);
		end
		if (cmd.mul2) begin
			dvd2_q <= m2[DIV_W-1:0];
		end
		if (cmd.phase) begin
			step_q <= step_w[9:0];
			env_prod_q <= 24'(mag_q) * 24'(cfg.gain);
		end
		if (cmd.scale) begin
			env_q <= (|env_prod_q[23:11]) ? 8'hFF : env_prod_q[10:3];
			freq_prod_q <= 26'(step_q) * 26'(cfg.freq_scale);
		end
		if (cmd.pwm) begin
			pwm_prod_q <= 24'(env_q) * 24'(cfg.pwm_half_count);
		end
		if (cmd.load_out) begin
			envelope_q <= env_q;
			pwm_level_q <= pwm_prod_q[23:8];
			freq_offset_q <= cfg.lsb_mode ? -freq_prod_q[23:8] : freq_prod_q[23:8];
		end
	end

	assign envelope = envelope_q;
	assign pwm_level = pwm_level_q;
	assign freq_offset = freq_offset_q;

endmodule
`default_nettype wire

// ===== sv/ssbpm_ctrl.sv =====
// Controller: sequences one decimated item through the datapath.
`default_nettype none
module ssbpm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             enable,
	input  wire logic             out_ready,
	input  wire ssbpm_pkg::stat_t stat,
	output logic                  in_ready,
	output logic                  out_valid,
	output ssbpm_pkg::cmd_t       cmd
);
	import ssbpm_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && enable && stat.period_done) begin
					state_d = S_FILT;
				end
			end
			S_FILT:    state_d = S_SHIFT;
			S_SHIFT:   state_d = S_HILB;
			S_HILB:    state_d = S_POLAR;
			S_POLAR:   state_d = S_DIV1_GO;
			S_DIV1_GO: state_d = S_DIV1;
			S_DIV1: begin
				if (stat.div_done) begin
					state_d = S_MUL2;
				end
			end
			S_MUL2:    state_d = S_DIV2_GO;
			S_DIV2_GO: state_d = S_DIV2;
			S_DIV2: begin
				if (stat.div_done) begin
					state_d = S_PHASE;
				end
			end
			S_PHASE:   state_d = S_SCALE;
			S_SCALE:   state_d = S_PWM;
			S_PWM:     state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:    cmd.acc = accept && enable;
			S_FILT:    cmd.filt = 1'b1;
			S_SHIFT:   cmd.shift = 1'b1;
			S_HILB:    cmd.hilb = 1'b1;
			S_POLAR:   cmd.polar = 1'b1;
			S_DIV1_GO: cmd.div_start = 1'b1;
			S_DIV1:    cmd.div_sel = 1'b0;
			S_MUL2:    cmd.mul2 = 1'b1;
			S_DIV2_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
			end
			S_DIV2:    cmd.div_sel = 1'b1;
			S_PHASE:   cmd.phase = 1'b1;
			S_SCALE:   cmd.scale = 1'b1;
			S_PWM:     cmd.pwm = 1'b1;
			S_OUT:     cmd.load_out = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/ssb_polar_modulator.sv =====
// SSB polar modulator top level: configuration registers, controller and datapath.
// Samples are accepted in the idle state while a decimation period fills; the sample
// that completes a period starts a sequence (filter, delay-line shift, Hilbert FIR,
// polar conversion, two bit-serial arctangent divisions on one shared divider, four
// registered multiplies, output load), during which no sample is taken. The output
// load waits, stretching the sequence, while a previous result has not been taken.
// The result waits in an output register, so the next sample is taken while it is
// still pending. Configuration is written through cfg_valid/cfg_ready (always ready)
// and must only change while the block is idle.
// With enable low, samples are accepted and dropped.
`default_nettype none
module ssb_polar_modulator #(
	parameter int unsigned DECIMATION = ssbpm_pkg::DECIMATION_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [15:0]                sample,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             envelope,
	output logic [15:0]                            pwm_level,
	output logic signed [15:0]                     freq_offset,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ssbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [15:0]                       cfg_data
);
	import ssbpm_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.lsb_mode <= 1'b0;
			cfg_q.gain <= GAIN_RST;
			cfg_q.freq_scale <= FREQ_SCALE_RST;
			cfg_q.pwm_half_count <= PWM_HALF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:     cfg_q.enable <= cfg_data[0];
				REG_LSB_MODE:   cfg_q.lsb_mode <= cfg_data[0];
				REG_GAIN:       cfg_q.gain <= cfg_data[7:0];
				REG_FREQ_SCALE: cfg_q.freq_scale <= cfg_data;
				REG_PWM_HALF:   cfg_q.pwm_half_count <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	ssbpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.enable    (cfg_q.enable),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	ssbpm_dp #(
		.DECIMATION (DECIMATION)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.sample      (sample),
		.stat        (stat),
		.envelope    (envelope),
		.pwm_level   (pwm_level),
		.freq_offset (freq_offset)
	);

`ifndef SYNTH
	// a dropped item must leave the block idle
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !cfg_q.enable) |=> in_ready)
		else $error("disabled item started processing");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || out_ready))
		else $error("pending result overwritten");

	// a result shows up only after a load
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("result valid without load");
`endif

endmodule
`default_nettype wire
